// ----- hdl/ccttl_pkg.sv -----
`default_nettype none

package ccttl_pkg;

   // sizes
   localparam int DEFAULT_ENTRIES = 4;
   localparam int DATA_W          = 64;
   localparam int CRED_W          = 4 * DATA_W;
   localparam int AGE_W           = 8;
   localparam int CODE_W          = 8;
   localparam int CMD_W           = 2;
   localparam int STATUS_W        = 2;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [AGE_W-1:0] AGE_MAX        = 8'd255;
   localparam logic [AGE_W-1:0] AGE_ZERO       = 8'd0;
   localparam logic [AGE_W-1:0] LIFETIME_RESET = 8'd6;
   localparam logic [CODE_W-1:0] CODE_ACCEPTED = 8'd0;

   // request commands
   localparam logic [CMD_W-1:0] CMD_AUTH    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESULT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] ST_SUCCESS = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DENIED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PENDING = 2'd2;

   // register word index (paddr[2])
   localparam logic REG_LIFETIME = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AUTH,
      S_AUTH_END,
      S_RESULT,
      S_SCAN,
      S_STORE,
      S_TICK,
      S_RESTART
   } state_type;

   typedef struct packed {
      logic load;         // latch request beat, restart walk
      logic walk;         // read next cache entry for compare
      logic scan;         // next step of the min-age search
      logic auth_finish;  // resolve auth and emit
      logic deny_result;  // server refused: clear pending, emit denied
      logic store;        // server accepted: fill victim, emit success
      logic tick;         // age every live entry
      logic restart;      // link restart: drop pending
   } dp_cmd_type;

   typedef struct packed {
      logic pending;
      logic code_ok;
      logic cnt_end;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- hdl/ccttl_req_if.sv -----
`default_nettype none

interface ccttl_req_if;
   logic                                valid;
   logic                                ready;
   logic [ccttl_pkg::CMD_W-1:0]         cmd;
   logic [ccttl_pkg::DATA_W-1:0]        user_hi;
   logic [ccttl_pkg::DATA_W-1:0]        user_lo;
   logic [ccttl_pkg::DATA_W-1:0]        pass_hi;
   logic [ccttl_pkg::DATA_W-1:0]        pass_lo;
   logic                                link_up;
   logic [ccttl_pkg::CODE_W-1:0]        result_code;

   modport source (output valid, cmd, user_hi, user_lo, pass_hi, pass_lo, link_up,
                   result_code, input ready);
   modport sink (input valid, cmd, user_hi, user_lo, pass_hi, pass_lo, link_up,
                 result_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/ccttl_rsp_if.sv -----
`default_nettype none

interface ccttl_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ccttl_pkg::STATUS_W-1:0]      status;
   logic                                from_cache;

   modport source (output valid, status, from_cache, input ready);
   modport sink (input valid, status, from_cache, output ready);
endinterface

`default_nettype wire

// ----- hdl/ccttl_dp.sv -----
`default_nettype none

module ccttl_dp #(
   parameter int ENTRIES = ccttl_pkg::DEFAULT_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ccttl_pkg::dp_cmd_type              cmd,
   output ccttl_pkg::dp_sts_type              sts,
   input  logic [ccttl_pkg::CRED_W-1:0]       req_cred,
   input  logic                               req_link_up,
   input  logic [ccttl_pkg::CODE_W-1:0]       req_result_code,
   input  logic [ccttl_pkg::AGE_W-1:0]        lifetime,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [ccttl_pkg::STATUS_W-1:0]     rsp_status,
   output logic                               rsp_from_cache
);
   import ccttl_pkg::*;

   localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CntW = $clog2(ENTRIES + 1);
   localparam logic [CntW-1:0] CntEnd = CntW'(ENTRIES);

   // request beat
   logic [CRED_W-1:0]   req_cred_ff, req_cred_in;
   logic                link_ff, link_in;
   logic                code_ok_ff, code_ok_in;

   // outstanding server request
   logic                pending_ff, pending_in;
   logic [CRED_W-1:0]   held_ff, held_in;

   // cache store, lifetimes in flops
   logic [CRED_W-1:0]   cred_mem [ENTRIES];
   logic [CRED_W-1:0]   rd_data_ff;
   logic                rd_live_ff, rd_live_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [AGE_W-1:0]    age_ff [ENTRIES];
   logic [AGE_W-1:0]    age_in [ENTRIES];

   // walk / search
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                hit_ff, hit_in;
   logic [AGE_W-1:0]    least_ff, least_in;
   logic [IdxW-1:0]     victim_ff, victim_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                from_cache_ff, from_cache_in;

   logic [IdxW-1:0]     idx;
   logic                in_range;
   logic                hit_now;
   logic                hit_any;

   assign idx      = cnt_ff[IdxW-1:0];
   assign in_range = (cnt_ff != CntEnd);
   assign hit_now  = cmp_valid_ff & rd_live_ff & (rd_data_ff == req_cred_ff);
   assign hit_any  = hit_ff | hit_now;

   always_comb begin
      req_cred_in   = req_cred_ff;
      link_in       = link_ff;
      code_ok_in    = code_ok_ff;
      pending_in    = pending_ff;
      held_in       = held_ff;
      rd_live_in    = rd_live_ff;
      cmp_valid_in  = 1'b0;
      age_in        = age_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_any;
      least_in      = least_ff;
      victim_in     = victim_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      status_in     = status_ff;
      from_cache_in = from_cache_ff;

      if (cmd.load) begin
         req_cred_in = req_cred;
         link_in     = req_link_up;
         code_ok_in  = (req_result_code == CODE_ACCEPTED);
         cnt_in      = '0;
         hit_in      = 1'b0;
         least_in    = AGE_MAX;
         victim_in   = '0;
      end

      if (cmd.walk && in_range) begin
         cmp_valid_in = 1'b1;
         rd_live_in   = (age_ff[idx] != AGE_ZERO);
         cnt_in       = cnt_ff + 1'b1;
      end

      // strict less-than keeps the lowest index on ties
      if (cmd.scan && in_range) begin
         if (age_ff[idx] < least_ff) begin
            least_in  = age_ff[idx];
            victim_in = idx;
         end
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.auth_finish) begin
         rsp_valid_in  = 1'b1;
         from_cache_in = 1'b0;
         if (hit_any) begin
            status_in     = ST_SUCCESS;
            from_cache_in = 1'b1;
         end else if (!link_ff || pending_ff) begin
            status_in = ST_DENIED;
         end else begin
            pending_in = 1'b1;
            held_in    = req_cred_ff;
            status_in  = ST_PENDING;
         end
      end

      if (cmd.deny_result) begin
         pending_in    = 1'b0;
         rsp_valid_in  = 1'b1;
         status_in     = ST_DENIED;
         from_cache_in = 1'b0;
      end

      if (cmd.store) begin
         pending_in        = 1'b0;
         age_in[victim_ff] = lifetime;
         rsp_valid_in      = 1'b1;
         status_in         = ST_SUCCESS;
         from_cache_in     = 1'b0;
      end

      if (cmd.tick) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (age_ff[i] != AGE_ZERO) begin
               age_in[i] = age_ff[i] - 1'b1;
            end
         end
      end

      if (cmd.restart) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= AGE_ZERO;
         end
      end else begin
         pending_ff   <= pending_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         cnt_ff       <= cnt_in;
         age_ff       <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      req_cred_ff   <= req_cred_in;
      link_ff       <= link_in;
      code_ok_ff    <= code_ok_in;
      held_ff       <= held_in;
      rd_live_ff    <= rd_live_in;
      least_ff      <= least_in;
      victim_ff     <= victim_in;
      status_ff     <= status_in;
      from_cache_ff <= from_cache_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         cred_mem[victim_ff] <= held_ff;
      end
      if (cmd.walk && in_range) begin
         rd_data_ff <= cred_mem[idx];
      end
   end

   assign sts.pending  = pending_ff;
   assign sts.code_ok  = code_ok_ff;
   assign sts.cnt_end  = ~in_range;
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_from_cache = from_cache_ff;

endmodule

`default_nettype wire

// ----- hdl/ccttl_ctrl.sv -----
`default_nettype none

module ccttl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ccttl_pkg::CMD_W-1:0]   req_cmd,
   output logic                          req_ready,
   input  ccttl_pkg::dp_sts_type         sts,
   output ccttl_pkg::dp_cmd_type         cmd
);
   import ccttl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_AUTH:    state_in = S_AUTH;
                  CMD_RESULT:  state_in = S_RESULT;
                  CMD_TICK:    state_in = S_TICK;
                  CMD_RESTART: state_in = S_RESTART;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_AUTH: begin
            if (sts.cnt_end) state_in = S_AUTH_END;
         end
         S_AUTH_END: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_RESULT: begin
            if (!sts.pending) begin
               state_in = S_IDLE;
            end else if (sts.code_ok) begin
               state_in = S_SCAN;
            end else if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (sts.cnt_end) state_in = S_STORE;
         end
         S_STORE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         S_TICK:    state_in = S_IDLE;
         S_RESTART: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_AUTH:     cmd.walk        = 1'b1;
         S_AUTH_END: cmd.auth_finish = sts.out_free;
         S_RESULT:   cmd.deny_result = sts.pending & ~sts.code_ok & sts.out_free;
         S_SCAN:     cmd.scan        = 1'b1;
         S_STORE:    cmd.store       = sts.out_free;
         S_TICK:     cmd.tick        = 1'b1;
         S_RESTART:  cmd.restart     = 1'b1;
         default:    cmd             = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/credential_cache_with_ttl.sv -----
`default_nettype none

// channel   dir  width / fields                                        beat taken when
// req_ch    in   cmd 2, user_hi/lo 64, pass_hi/lo 64, link_up 1, code 8  valid & ready
// rsp_ch    out  status 2, from_cache 1                                valid & ready
// apb       in   paddr 3, pwdata 32, prdata 32; lifetime at paddr 0    psel & penable & pwrite
//
// One request beat at a time. Auth: AUTH walks the store (one compare per cycle
// through the registered store read), then AUTH_END emits the result; the next beat
// is taken back in IDLE. Server result: an accepted one runs the min-age search in SCAN
// (one entry per cycle), then the fill and the success result in STORE; a refused one
// emits denied from RESULT. Stray server result, tick and link restart: no result beat.
// Reset clears pending, all lifetimes, the FSM and the result valid flag.
// A stalled rsp_ch holds the next result in its final state and req_ch ready low.

module credential_cache_with_ttl #(
   parameter int ENTRIES = ccttl_pkg::DEFAULT_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   ccttl_req_if.sink                           req_ch,
   ccttl_rsp_if.source                         rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ccttl_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ccttl_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ccttl_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready
);
   import ccttl_pkg::*;

   dp_cmd_type       cmd;
   dp_sts_type       sts;
   logic [AGE_W-1:0] lifetime_ff, lifetime_in;
   logic             reg_sel;
   logic [CRED_W-1:0] req_cred;

   // config register: word index is paddr[2], byte offset ignored
   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == REG_LIFETIME);

   always_comb begin
      lifetime_in = lifetime_ff;
      if (psel && penable && pwrite && reg_sel) begin
         lifetime_in = pwdata[AGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
      end else begin
         lifetime_ff <= lifetime_in;
      end
   end

   assign prdata = reg_sel ? {{(CSR_DATA_W-AGE_W){1'b0}}, lifetime_ff} : '0;

   // user first, password second, high half before low
   assign req_cred = {req_ch.user_hi, req_ch.user_lo, req_ch.pass_hi, req_ch.pass_lo};

   ccttl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ccttl_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_cred        (req_cred),
      .req_link_up     (req_ch.link_up),
      .req_result_code (req_ch.result_code),
      .lifetime        (lifetime_ff),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_from_cache  (rsp_ch.from_cache)
   );

endmodule

`default_nettype wire

// ----- hdl/ccttl_chk.sv -----
`default_nettype none

module ccttl_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ccttl_pkg::STATUS_W-1:0]    rsp_status,
   input logic                              rsp_from_cache
);
   import ccttl_pkg::*;

   // one request in flight: ready drops right after a request beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ccttl: request taken while another is in flight");

   // a cache hit is always a success
   a_cache_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_from_cache) |-> (rsp_status == ST_SUCCESS))
      else $error("ccttl: from_cache without success");

   // no result beat comes straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("ccttl: result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_from_cache)))
      else $error("ccttl: stalled result changed");

endmodule

bind credential_cache_with_ttl ccttl_chk u_ccttl_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_from_cache (rsp_ch.from_cache)
);

`default_nettype wire
